// File: hdl/adsd_pkg.sv
// Shared types, constants and the segment encoder for the deadband display block.
// No dependencies.
package adsd_pkg;

    localparam int DEADBAND_BITS = 4;
    localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = 4'd4;

    localparam int POS_BITS   = 2;
    localparam int DIGIT_BITS = 4;
    localparam int SEG_BITS   = 8;
    localparam int NUM_DIGITS = 4;
    localparam logic [POS_BITS-1:0] POS_UNITS = 2'd0;
    localparam logic [POS_BITS-1:0] POS_TOP   = POS_BITS'(NUM_DIGITS - 1);

    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_PAD_BITS = OUT_TDATA_W - POS_BITS - DIGIT_BITS - SEG_BITS;

    // v / 10 == (v * 52429) >> 19 for v < 43690
    localparam int RECIP_BITS  = 16;
    localparam logic [RECIP_BITS-1:0] RECIP_TEN = 16'd52429;
    localparam int RECIP_SHIFT = 19;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [POS_BITS-1:0]   position;
        logic [DIGIT_BITS-1:0] value;
        logic [SEG_BITS-1:0]   segments;
        logic                  last;
    } digit_t;

    // active low, bit0 = a ... bit7 = h
    function automatic logic [SEG_BITS-1:0] seg_encode(input logic [DIGIT_BITS-1:0] d);
        logic [SEG_BITS-1:0] s;
        unique case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/adc_deadband_seven_segment_display.sv
// Deadband-filtered converter sample to seven-segment digit stream.
// Throughput: one digit per cycle while m_axis_tready does not stall the output; a
// sample gives 1 to 4 digits. Input is taken while the two-entry queue has room.
// Reset (aresetn low, synchronous): held value 0, deadband 4, queue and outputs empty.
module adc_deadband_seven_segment_display #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [adsd_pkg::DEADBAND_BITS-1:0]     cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // digit_position, digit_value, segments, zero pad
    output logic [adsd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tlast    // last_digit
);
    import adsd_pkg::*;

    logic                   q_full;
    logic                   q_push;
    logic [SAMPLE_BITS-1:0] q_push_data;
    logic                   q_pop;
    logic                   q_not_empty;
    logic [SAMPLE_BITS-1:0] q_pop_data;
    digit_t                 out_digit;

    adsd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_ready  (s_axis_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    adsd_queue #(.WIDTH(SAMPLE_BITS)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    adsd_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_digit   (out_digit),
        .out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, out_digit.segments,
                           out_digit.value, out_digit.position};
    assign m_axis_tlast = out_digit.last;

endmodule

// File: hdl/adsd_front.sv
// Front end: takes samples, applies the deadband against the held value and
// pushes the value to show into the queue. Holds the deadband register. Uses adsd_pkg.
module adsd_front #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [adsd_pkg::DEADBAND_BITS-1:0]   cfg_wdata,
    input  logic                                 in_valid,
    input  logic [SAMPLE_BITS-1:0]               in_sample,
    output logic                                 in_ready,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [SAMPLE_BITS-1:0]               q_data
);
    import adsd_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    logic [DEADBAND_BITS-1:0] deadband_reg;
    logic [SAMPLE_BITS-1:0]   held_reg;
    logic [SAMPLE_BITS-1:0]   held_next;
    logic [SAMPLE_BITS-1:0]   diff;
    logic                     in_band;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign q_data   = held_next;

    always_comb begin
        diff    = (in_sample > held_reg) ? (in_sample - held_reg) : (held_reg - in_sample);
        in_band = (diff != '0) && (diff <= SAMPLE_BITS'(deadband_reg));
        priority if (in_sample == '0) begin
            held_next = '0;
        end else if (in_sample == FULL_SCALE) begin
            held_next = FULL_SCALE;
        end else if (held_reg == '0) begin
            held_next = in_sample;
        end else if (in_band) begin
            held_next = held_reg;
        end else begin
            held_next = in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RESET;
            held_reg     <= '0;
        end else begin
            if (cfg_we) begin
                deadband_reg <= cfg_wdata;
            end
            if (q_push) begin
                held_reg <= held_next;
            end
        end
    end

endmodule

// File: hdl/adsd_queue.sv
// Two-entry queue of values to show, between front and back end. Uses adsd_pkg.
module adsd_queue #(
    parameter int WIDTH = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    import adsd_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/adsd_back.sv
// Back end: splits a queued value into decimal digits, units first, one per cycle
// unless stalled; divide-by-ten reciprocal multiply; output register. Uses adsd_pkg.
module adsd_back #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  logic [SAMPLE_BITS-1:0] q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    output adsd_pkg::digit_t       out_digit,
    input  logic                   out_ready
);
    import adsd_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + RECIP_BITS;

    logic                   busy_reg;
    logic [SAMPLE_BITS-1:0] val_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic                   out_valid_reg;
    digit_t                 out_reg;

    logic [PROD_BITS-1:0]     prod;
    logic [SAMPLE_BITS-1:0]   quot;
    logic [SAMPLE_BITS+3:0]   ten_quot;
    logic [SAMPLE_BITS+3:0]   rem_wide;
    logic [DIGIT_BITS-1:0]    rem;
    logic                     is_last;
    logic                     out_free;
    logic                     emit;
    logic                     load;
    digit_t                   digit_next;

    always_comb begin
        prod     = PROD_BITS'(val_reg) * PROD_BITS'(RECIP_TEN);
        quot     = SAMPLE_BITS'(prod >> RECIP_SHIFT);
        ten_quot = ((SAMPLE_BITS + 4)'(quot) << 3) + ((SAMPLE_BITS + 4)'(quot) << 1);
        rem_wide = (SAMPLE_BITS + 4)'(val_reg) - ten_quot;
        rem      = rem_wide[DIGIT_BITS-1:0];
        is_last  = (quot == '0) || (pos_reg == POS_TOP);

        digit_next.position = pos_reg;
        digit_next.value    = rem;
        digit_next.segments = seg_encode(rem);
        digit_next.last     = is_last;

        out_free = !out_valid_reg || out_ready;
        emit     = busy_reg && out_free;
        load     = q_not_empty && (!busy_reg || (emit && is_last));
    end

    assign q_pop     = load;
    assign out_valid = out_valid_reg;
    assign out_digit = out_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            val_reg <= q_data;
        end else if (emit) begin
            val_reg <= quot;
        end
        if (emit) begin
            out_reg <= digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_UNITS;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                pos_reg  <= POS_UNITS;
            end else if (emit) begin
                if (is_last) begin
                    busy_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/adsd_checker.sv
// Port-level assertions for adc_deadband_seven_segment_display, with bind.
// Uses adsd_pkg.
module adsd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [adsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);
    import adsd_pkg::*;

    logic [POS_BITS-1:0]   pos;
    logic [DIGIT_BITS-1:0] val;
    logic [SEG_BITS-1:0]   seg;

    assign pos = m_axis_tdata[POS_BITS-1:0];
    assign val = m_axis_tdata[POS_BITS+DIGIT_BITS-1:POS_BITS];
    assign seg = m_axis_tdata[POS_BITS+DIGIT_BITS+SEG_BITS-1:POS_BITS+DIGIT_BITS];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (val <= 4'd9) && (seg == seg_encode(val)))
        else $error("digit or segment pattern wrong");

    a_top_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (pos == POS_TOP) |-> m_axis_tlast)
        else $error("thousands digit not marked last");

    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
            !m_axis_tvalid || (pos == POS_UNITS))
        else $error("run does not start at units");

    a_run_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (pos == $past(pos) + 1'b1))
        else $error("digit position skipped");

endmodule

bind adc_deadband_seven_segment_display adsd_checker u_adsd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
